// ----- hdl/lcp_pkg.sv -----
// Shared types, constants and tables for the LED column pulse effect.
// Holds the microcode format and program, the column tables and the sine
// table builder. No dependencies.
package lcp_pkg;

  // Geometry and register map
  localparam int COL_W   = 4;
  localparam int IDX_W   = 10;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_COLOR    = 2'd1;
  localparam logic [1:0] REG_FLIP     = 2'd2;
  localparam logic [1:0] REG_INTERVAL = 2'd3;

  localparam logic [15:0] INTERVAL_RESET = 16'd50;

  // 4/1000 rad per ms in phase units, Q16
  localparam logic [31:0] TIME_SCALE_Q16 = 32'd2734261;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  localparam int QSINE_DEPTH = 257;
  localparam logic [15:0] PULSE_MID = 16'd32768;

  typedef struct packed {
    logic        enable;
    logic [23:0] base_color;
    logic        flip;
    logic [15:0] interval;
  } cfg_t;

  // Microcode
  typedef logic [2:0] step_t;

  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_CHECK = 3'd1;
  localparam step_t STEP_TIME  = 3'd2;
  localparam step_t STEP_PHASE = 3'd3;
  localparam step_t STEP_ROM   = 3'd4;
  localparam step_t STEP_PULSE = 3'd5;
  localparam step_t STEP_CHAN  = 3'd6;
  localparam step_t STEP_EMIT  = 3'd7;

  typedef enum logic [1:0] {
    COND_NEXT,   // always advance
    COND_IN,     // hold until an item arrives
    COND_DUE,    // advance if a frame is due, else jump to target
    COND_EMIT    // hold until output slot frees, then loop or finish
  } cond_t;

  typedef struct packed {
    logic take_in;
    logic chk;
    logic time_calc;
    logic phase_calc;
    logic rom_rd;
    logic pulse_mul;
    logic chan_mul;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic due;
    logic col_last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    ctl_t  ops;
    cond_t cond;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '0;
    w.cond = COND_NEXT;
    w.target = STEP_WAIT;
    case (s)
      STEP_WAIT: begin
        w.ops.take_in = 1'b1;
        w.cond = COND_IN;
      end
      STEP_CHECK: begin
        w.ops.chk = 1'b1;
        w.cond = COND_DUE;
        w.target = STEP_WAIT;
      end
      STEP_TIME:  w.ops.time_calc  = 1'b1;
      STEP_PHASE: w.ops.phase_calc = 1'b1;
      STEP_ROM:   w.ops.rom_rd     = 1'b1;
      STEP_PULSE: w.ops.pulse_mul  = 1'b1;
      STEP_CHAN:  w.ops.chan_mul   = 1'b1;
      STEP_EMIT: begin
        w.ops.emit = 1'b1;
        w.cond = COND_EMIT;
        w.target = STEP_PHASE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // Column brightness ramp, Q1.15
  function automatic logic [15:0] column_ramp(logic [COL_W-1:0] c);
    logic [15:0] r;
    case (c)
      4'd0, 4'd15: r = 16'd9830;
      4'd1, 4'd14: r = 16'd13107;
      4'd2, 4'd13: r = 16'd16384;
      4'd3, 4'd12: r = 16'd19661;
      4'd4, 4'd11: r = 16'd22938;
      4'd5, 4'd10: r = 16'd26214;
      4'd6, 4'd9:  r = 16'd29491;
      4'd7, 4'd8:  r = 16'd32768;
      default:     r = 16'd0;
    endcase
    return r;
  endfunction

  // Per-column phase offset of d rad, d = 0..7
  function automatic logic [15:0] offset_phase(logic [2:0] d);
    logic [15:0] p;
    case (d)
      3'd0: p = 16'd0;
      3'd1: p = 16'd10430;
      3'd2: p = 16'd20861;
      3'd3: p = 16'd31291;
      3'd4: p = 16'd41722;
      3'd5: p = 16'd52152;
      3'd6: p = 16'd62582;
      3'd7: p = 16'd7477;
      default: p = 16'd0;
    endcase
    return p;
  endfunction

  // Quarter-wave sine, evaluated at elaboration (Taylor series to x^13)
  typedef logic [14:0] qsine_tab_t [QSINE_DEPTH];

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t        tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        v;
    for (int j = 0; j < QSINE_DEPTH; j++) begin
      x    = (64'(j) * HALF_PI_Q30) >> 8;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      acc  = acc + $signed(term);
      if (acc < 0) acc = 0;
      v = ($unsigned(acc) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      tab[j] = v[14:0];
    end
    return tab;
  endfunction

endpackage

// ----- hdl/lcp_cfg.sv -----
// APB-style configuration registers for the LED column pulse effect.
// Depends on lcp_pkg.
module lcp_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcp_pkg::ADDR_W-1:0] paddr,
  input  logic [lcp_pkg::DATA_W-1:0] pwdata,
  output logic [lcp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lcp_pkg::cfg_t              cfg
);
  import lcp_pkg::*;

  logic       wr;
  logic [1:0] sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign sel    = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable     <= 1'b0;
      cfg.base_color <= '0;
      cfg.flip       <= 1'b0;
      cfg.interval   <= INTERVAL_RESET;
    end else if (wr) begin
      case (sel)
        REG_ENABLE:   cfg.enable     <= pwdata[0];
        REG_COLOR:    cfg.base_color <= pwdata[23:0];
        REG_FLIP:     cfg.flip       <= pwdata[0];
        REG_INTERVAL: cfg.interval   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (sel)
      REG_ENABLE:   prdata = {31'b0, cfg.enable};
      REG_COLOR:    prdata = {8'b0, cfg.base_color};
      REG_FLIP:     prdata = {31'b0, cfg.flip};
      REG_INTERVAL: prdata = {16'b0, cfg.interval};
      default:      prdata = '0;
    endcase
  end

endmodule

// ----- hdl/lcp_useq.sv -----
// Microcode sequencer: step counter, control-word table and jump logic.
// Depends on lcp_pkg.
module lcp_useq (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lcp_pkg::stat_t stat,
  output lcp_pkg::ctl_t  ctl
);
  import lcp_pkg::*;

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   go;

  assign uw       = ucode(pc);
  assign in_stall = ~uw.ops.take_in;

  // condition evaluation and next step
  always_comb begin
    go      = 1'b1;
    pc_next = pc + 3'd1;
    case (uw.cond)
      COND_NEXT: ;
      COND_IN: begin
        go = in_valid;
        if (!in_valid) pc_next = pc;
      end
      COND_DUE: begin
        if (!stat.due) pc_next = uw.target;
      end
      COND_EMIT: begin
        go = stat.out_free;
        if (!stat.out_free) pc_next = pc;
        else if (stat.col_last) pc_next = STEP_WAIT;
        else pc_next = uw.target;
      end
      default: pc_next = STEP_WAIT;
    endcase
    ctl = go ? uw.ops : '0;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- hdl/lcp_sine_rom.sv -----
// Quarter-wave sine ROM (257 x Q0.15 magnitude) with registered read.
// Depends on lcp_pkg.
module lcp_sine_rom (
  input  logic        clk,
  input  logic        rd_en,
  input  logic [8:0]  addr,
  output logic [14:0] data
);
  import lcp_pkg::*;

  localparam qsine_tab_t QTAB = build_qsine();

  always_ff @(posedge clk) begin
    if (rd_en) data <= QTAB[addr];
  end

endmodule

// ----- hdl/lcp_datapath.sv -----
// Datapath for the pulse effect: frame check, phase, sine lookup,
// brightness multiplies and the output register. Depends on lcp_pkg
// and lcp_sine_rom.
module lcp_datapath #(
  parameter int ROWS       = 8,
  parameter int LEFT_BASE  = 0,
  parameter int RIGHT_BASE = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lcp_pkg::ctl_t              ctl,
  output lcp_pkg::stat_t             stat,
  input  lcp_pkg::cfg_t              cfg,
  input  logic [31:0]                time_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lcp_pkg::COL_W-1:0]  column,
  output logic [lcp_pkg::IDX_W-1:0]  first_index,
  output logic [7:0]                 red_out,
  output logic [7:0]                 green_out,
  output logic [7:0]                 blue_out,
  output logic                       last
);
  import lcp_pkg::*;

  localparam logic [IDX_W-1:0] LEFT_FIRST  = IDX_W'(LEFT_BASE + (ROWS - 2) * 8);
  localparam logic [IDX_W-1:0] RIGHT_FIRST = IDX_W'(RIGHT_BASE + (ROWS - 2) * 8);

  logic [31:0]      t_reg;
  logic [31:0]      last_frame;
  logic [15:0]      tp;
  logic [COL_W-1:0] col;
  logic [8:0]       rom_addr;
  logic             sine_neg;
  logic [14:0]      sine_mag;
  logic [31:0]      prod;
  logic [7:0]       red_s, green_s, blue_s;

  logic [31:0] elapsed;
  logic [31:0] tmul;
  logic        right;
  logic [15:0] tsign;
  logic [15:0] phase;
  logic [15:0] pulse;
  logic [39:0] red_full, green_full, blue_full;

  // frame due check
  assign elapsed       = t_reg - last_frame;
  assign stat.due      = cfg.enable & (elapsed >= {16'b0, cfg.interval});
  assign stat.col_last = (col == COL_W'(15));
  assign stat.out_free = ~out_valid | ~out_stall;

  // time term and column phase
  assign tmul  = t_reg * TIME_SCALE_Q16;
  assign right = col[3];
  assign tsign = (right ^ cfg.flip) ? (16'd0 - tp) : tp;
  assign phase = right ? (tsign - offset_phase(col[2:0]))
                       : (tsign + offset_phase(~col[2:0]));

  // pulse factor (sin + 1) in Q1.15
  assign pulse = sine_neg ? (PULSE_MID - {1'b0, sine_mag})
                          : (PULSE_MID + {1'b0, sine_mag});

  // channel scaling, product >> 31
  assign red_full   = {32'b0, cfg.base_color[23:16]} * {8'b0, prod};
  assign green_full = {32'b0, cfg.base_color[15:8]}  * {8'b0, prod};
  assign blue_full  = {32'b0, cfg.base_color[7:0]}   * {8'b0, prod};

  lcp_sine_rom u_rom (
    .clk   (clk),
    .rd_en (ctl.rom_rd),
    .addr  (rom_addr),
    .data  (sine_mag)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame <= '0;
    end else if (ctl.chk && stat.due) begin
      last_frame <= t_reg;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.take_in) t_reg <= time_ms;
    if (ctl.time_calc) tp <= tmul[31:16];
    if (ctl.chk) col <= '0;
    else if (ctl.emit) col <= col + COL_W'(1);
    if (ctl.phase_calc) begin
      rom_addr <= phase[14] ? (9'd256 - {1'b0, phase[13:6]}) : {1'b0, phase[13:6]};
      sine_neg <= phase[15];
    end
    if (ctl.pulse_mul) prod <= column_ramp(col) * pulse;
    if (ctl.chan_mul) begin
      red_s   <= red_full[38:31];
      green_s <= green_full[38:31];
      blue_s  <= blue_full[38:31];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      column      <= col;
      first_index <= (right ? RIGHT_FIRST : LEFT_FIRST) + IDX_W'(col[2:0]);
      red_out     <= red_s;
      green_out   <= green_s;
      blue_out    <= blue_s;
      last        <= stat.col_last;
    end
  end

endmodule

// ----- hdl/led_column_pulse_effect.sv -----
// LED column pulse effect: takes one millisecond tick per item and, when a
// frame is due, emits 16 column colors in column order, the last one
// flagged. A tick that renders nothing passes only the wait and check
// steps; a frame runs wait, check and time, then per column the five-step
// loop of the microcode sequencer (phase, sine ROM read, ramp multiply,
// channel multiply, emit, held by output stall) sharing one sine ROM port.
// The next tick is taken once the last column has entered the output
// register. Depends on lcp_pkg, lcp_cfg, lcp_useq, lcp_datapath.
module led_column_pulse_effect #(
  parameter int ROWS       = 8,
  parameter int LEFT_BASE  = 0,
  parameter int RIGHT_BASE = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcp_pkg::ADDR_W-1:0] paddr,
  input  logic [lcp_pkg::DATA_W-1:0] pwdata,
  output logic [lcp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                time_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lcp_pkg::COL_W-1:0]  column,
  output logic [lcp_pkg::IDX_W-1:0]  first_index,
  output logic [7:0]                 red_out,
  output logic [7:0]                 green_out,
  output logic [7:0]                 blue_out,
  output logic                       last
);
  import lcp_pkg::*;

  cfg_t  cfg;
  ctl_t  ctl;
  stat_t stat;

  lcp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcp_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  lcp_datapath #(
    .ROWS       (ROWS),
    .LEFT_BASE  (LEFT_BASE),
    .RIGHT_BASE (RIGHT_BASE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cfg         (cfg),
    .time_ms     (time_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .column      (column),
    .first_index (first_index),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .last        (last)
  );

endmodule
